// ----- rtl/bta_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bta_pkg
// types, codes and constants shared by the boundary-tag allocator modules
// ----------------------------------------------------------------------------
package bta_pkg;

	localparam int HEAP_WORDS = 65536;
	localparam int WADDR_W    = $clog2(HEAP_WORDS);
	localparam int TAG_W      = 19;
	localparam int BA_W       = 21;
	localparam int BRK_W      = $clog2(HEAP_WORDS * 4 + 1);
	localparam int CMD_W      = 2;
	localparam int REQ_W      = 19;
	localparam int FADDR_W    = 18;
	localparam int ADDR_W     = 18;
	localparam int STAT_W     = 2;
	localparam int CHUNK_W    = 19;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 24;

	localparam logic [BA_W-1:0]    HEAP_BYTES   = BA_W'(HEAP_WORDS * 4);
	localparam logic [BA_W-1:0]    WORD         = 21'd4;
	localparam logic [BA_W-1:0]    DWORD        = 21'd8;
	localparam logic [BA_W-1:0]    MIN_BLOCK    = 21'd16;
	localparam logic [BA_W-1:0]    ALIGN_PAD    = 21'd15;
	localparam logic [BA_W-1:0]    SIZE_MASK    = ~21'h7;
	localparam logic [BA_W-1:0]    LIST_START   = 21'd8;
	localparam logic [BRK_W-1:0]   INIT_BREAK   = BRK_W'(16);
	localparam logic [TAG_W-1:0]   TAG_SIZE_MSK = ~19'h7;
	localparam logic [TAG_W-1:0]   ALLOC_BIT    = 19'd1;
	localparam logic [TAG_W-1:0]   PROLOGUE_TAG = 19'd9;
	localparam logic [CHUNK_W-1:0] CHUNK_RESET  = 19'd4096;

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT  = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_FREE  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_ZERO = 2'd1,
		STAT_OOM  = 2'd2
	} stat_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_INIT,
		ST_FIT_RD,
		ST_FIT_CHK,
		ST_GROW_CALC,
		ST_GROW_CHK,
		ST_GROW_W1,
		ST_GROW_W2,
		ST_GROW_W3,
		ST_MRG_P,
		ST_MRG_N,
		ST_MRG_D,
		ST_MRG_W1,
		ST_MRG_W2,
		ST_FREE_RD,
		ST_FREE_DAT,
		ST_FREE_W1,
		ST_FREE_W2,
		ST_PLACE_CALC,
		ST_PLACE_W1,
		ST_PLACE_W2,
		ST_PLACE_W3,
		ST_PLACE_W4,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [FADDR_W-1:0] free_addr;
		logic [REQ_W-1:0]   req_bytes;
		cmd_t               cmd;
	} req_t;

	typedef struct packed {
		stat_t             status;
		logic [ADDR_W-1:0] addr;
	} res_t;

	// tag words of a fresh heap: pad, prologue header/footer, epilogue
	function automatic logic [TAG_W-1:0] init_tag(input logic [1:0] idx);
		logic [TAG_W-1:0] t;
		case (idx)
			2'd0:    t = '0;
			2'd1:    t = PROLOGUE_TAG;
			2'd2:    t = PROLOGUE_TAG;
			default: t = ALLOC_BIT;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/bta_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bta_engine
// command sequencer around the tag memory: init, first-fit walk, grow, place,
// free and coalescing, one tag read or one tag write per cycle
// ----------------------------------------------------------------------------
module bta_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bta_pkg::CHUNK_W-1:0]   chunk,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  bta_pkg::req_t                 in_req,
	output logic                          res_valid,
	input  logic                          res_ready,
	output bta_pkg::res_t                 res
);

	localparam int BA_W  = bta_pkg::BA_W;
	localparam int TAG_W = bta_pkg::TAG_W;

	bta_pkg::state_t state_q, state_d, ret_st;

	logic [bta_pkg::BRK_W-1:0] brk_q;
	logic [1:0]                init_cnt_q;

	bta_pkg::cmd_t             op_q;
	logic [BA_W-1:0]           need_q, bytes_q, bp_q, s_q, gsz_q;
	logic [BA_W-1:0]           wa1_q, wa2_q, wsz_q, rem_q;
	logic [TAG_W-1:0]          p_q;
	logic [bta_pkg::FADDR_W-1:0] fa_q;
	logic                      split_q;
	logic [bta_pkg::ADDR_W-1:0] res_addr_q;
	bta_pkg::stat_t            res_status_q;

	// tag memory
	logic [TAG_W-1:0] mem [bta_pkg::HEAP_WORDS];
	logic [TAG_W-1:0] ram_rdata_q;
	logic             rd_oob_q;
	logic             wr_en;
	logic [BA_W-1:0]  wr_ba, rd_ba;
	logic [TAG_W-1:0] wr_tag, rd_tag;
	logic [BA_W-1:0]  rd_size, psz, brk_ext, fa_ext, need_d, chunk_eff;

	assign rd_tag  = rd_oob_q ? '0 : ram_rdata_q;
	assign rd_size = BA_W'(rd_tag & bta_pkg::TAG_SIZE_MSK);
	assign psz     = BA_W'(p_q & bta_pkg::TAG_SIZE_MSK);
	assign brk_ext = BA_W'(brk_q);
	assign fa_ext  = BA_W'(fa_q);
	assign chunk_eff = (BA_W'(chunk) < bta_pkg::MIN_BLOCK) ? bta_pkg::MIN_BLOCK : BA_W'(chunk);
	assign need_d  = (BA_W'(in_req.req_bytes) <= bta_pkg::DWORD) ? bta_pkg::MIN_BLOCK
		: ((BA_W'(in_req.req_bytes) + bta_pkg::ALIGN_PAD) & bta_pkg::SIZE_MASK);

	always_ff @(posedge clk) begin
		if (wr_en && (wr_ba < bta_pkg::HEAP_BYTES)) begin
			mem[wr_ba[bta_pkg::WADDR_W+1:2]] <= wr_tag;
		end
		ram_rdata_q <= mem[rd_ba[bta_pkg::WADDR_W+1:2]];
		rd_oob_q    <= rd_ba >= bta_pkg::HEAP_BYTES;
	end

	assign ret_st = (op_q == bta_pkg::CMD_ALLOC) ? bta_pkg::ST_PLACE_CALC : bta_pkg::ST_DONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bta_pkg::ST_IDLE;
			brk_q      <= '0;
			init_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bta_pkg::ST_INIT) begin
				init_cnt_q <= init_cnt_q + 2'd1;
				if (init_cnt_q == 2'd3) begin
					brk_q <= bta_pkg::INIT_BREAK;
				end
			end
			if ((state_q == bta_pkg::ST_GROW_CHK) &&
			    !((brk_ext + gsz_q) > bta_pkg::HEAP_BYTES)) begin
				brk_q <= bta_pkg::BRK_W'(brk_ext + gsz_q);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		wr_en     = 1'b0;
		wr_ba     = '0;
		wr_tag    = '0;
		rd_ba     = '0;
		unique case (state_q)
			bta_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_req.cmd)
						bta_pkg::CMD_INIT:  state_d = bta_pkg::ST_INIT;
						bta_pkg::CMD_ALLOC: begin
							if ((in_req.req_bytes == '0) || (brk_q == '0))
								state_d = bta_pkg::ST_DONE;
							else
								state_d = bta_pkg::ST_FIT_RD;
						end
						bta_pkg::CMD_FREE: begin
							state_d = (brk_q == '0) ? bta_pkg::ST_DONE : bta_pkg::ST_FREE_RD;
						end
						default: state_d = bta_pkg::ST_DONE;
					endcase
				end
			end
			bta_pkg::ST_INIT: begin
				wr_en  = 1'b1;
				wr_ba  = BA_W'({init_cnt_q, 2'b00});
				wr_tag = bta_pkg::init_tag(init_cnt_q);
				if (init_cnt_q == 2'd3) state_d = bta_pkg::ST_GROW_CALC;
			end
			bta_pkg::ST_FIT_RD: begin
				if (bp_q > bta_pkg::HEAP_BYTES) begin
					state_d = bta_pkg::ST_GROW_CALC;
				end else begin
					rd_ba   = bp_q - bta_pkg::WORD;
					state_d = bta_pkg::ST_FIT_CHK;
				end
			end
			bta_pkg::ST_FIT_CHK: begin
				if (rd_size == '0)
					state_d = bta_pkg::ST_GROW_CALC;
				else if ((rd_size >= need_q) && !rd_tag[0])
					state_d = bta_pkg::ST_PLACE_CALC;
				else
					state_d = bta_pkg::ST_FIT_RD;
			end
			bta_pkg::ST_GROW_CALC: state_d = bta_pkg::ST_GROW_CHK;
			bta_pkg::ST_GROW_CHK: begin
				if ((brk_ext + gsz_q) > bta_pkg::HEAP_BYTES)
					state_d = bta_pkg::ST_DONE;
				else
					state_d = bta_pkg::ST_GROW_W1;
			end
			bta_pkg::ST_GROW_W1: begin
				wr_en   = 1'b1;
				wr_ba   = bp_q - bta_pkg::WORD;
				wr_tag  = s_q[TAG_W-1:0];
				state_d = bta_pkg::ST_GROW_W2;
			end
			bta_pkg::ST_GROW_W2: begin
				wr_en   = 1'b1;
				wr_ba   = bp_q + s_q - bta_pkg::DWORD;
				wr_tag  = s_q[TAG_W-1:0];
				state_d = bta_pkg::ST_GROW_W3;
			end
			bta_pkg::ST_GROW_W3: begin
				wr_en   = 1'b1;
				wr_ba   = bp_q + s_q - bta_pkg::WORD;
				wr_tag  = bta_pkg::ALLOC_BIT;
				state_d = bta_pkg::ST_MRG_P;
			end
			bta_pkg::ST_MRG_P: begin
				rd_ba   = bp_q - bta_pkg::DWORD;
				state_d = bta_pkg::ST_MRG_N;
			end
			bta_pkg::ST_MRG_N: begin
				rd_ba   = bp_q + s_q - bta_pkg::WORD;
				state_d = bta_pkg::ST_MRG_D;
			end
			bta_pkg::ST_MRG_D: begin
				state_d = (p_q[0] && rd_tag[0]) ? ret_st : bta_pkg::ST_MRG_W1;
			end
			bta_pkg::ST_MRG_W1: begin
				wr_en   = 1'b1;
				wr_ba   = wa1_q;
				wr_tag  = s_q[TAG_W-1:0];
				state_d = bta_pkg::ST_MRG_W2;
			end
			bta_pkg::ST_MRG_W2: begin
				wr_en   = 1'b1;
				wr_ba   = wa2_q;
				wr_tag  = s_q[TAG_W-1:0];
				state_d = ret_st;
			end
			bta_pkg::ST_FREE_RD: begin
				rd_ba   = fa_ext - bta_pkg::WORD;
				state_d = bta_pkg::ST_FREE_DAT;
			end
			bta_pkg::ST_FREE_DAT: state_d = bta_pkg::ST_FREE_W1;
			bta_pkg::ST_FREE_W1: begin
				wr_en   = 1'b1;
				wr_ba   = bp_q - bta_pkg::WORD;
				wr_tag  = s_q[TAG_W-1:0];
				state_d = bta_pkg::ST_FREE_W2;
			end
			bta_pkg::ST_FREE_W2: begin
				wr_en   = 1'b1;
				wr_ba   = bp_q + s_q - bta_pkg::DWORD;
				wr_tag  = s_q[TAG_W-1:0];
				state_d = bta_pkg::ST_MRG_P;
			end
			bta_pkg::ST_PLACE_CALC: state_d = bta_pkg::ST_PLACE_W1;
			bta_pkg::ST_PLACE_W1: begin
				wr_en   = 1'b1;
				wr_ba   = bp_q - bta_pkg::WORD;
				wr_tag  = wsz_q[TAG_W-1:0] | bta_pkg::ALLOC_BIT;
				state_d = bta_pkg::ST_PLACE_W2;
			end
			bta_pkg::ST_PLACE_W2: begin
				wr_en   = 1'b1;
				wr_ba   = bp_q + wsz_q - bta_pkg::DWORD;
				wr_tag  = wsz_q[TAG_W-1:0] | bta_pkg::ALLOC_BIT;
				state_d = split_q ? bta_pkg::ST_PLACE_W3 : bta_pkg::ST_DONE;
			end
			bta_pkg::ST_PLACE_W3: begin
				wr_en   = 1'b1;
				wr_ba   = bp_q + need_q - bta_pkg::WORD;
				wr_tag  = rem_q[TAG_W-1:0];
				state_d = bta_pkg::ST_PLACE_W4;
			end
			bta_pkg::ST_PLACE_W4: begin
				wr_en   = 1'b1;
				wr_ba   = bp_q + s_q - bta_pkg::DWORD;
				wr_tag  = rem_q[TAG_W-1:0];
				state_d = bta_pkg::ST_DONE;
			end
			bta_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) state_d = bta_pkg::ST_IDLE;
			end
			default: state_d = bta_pkg::ST_IDLE;
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			bta_pkg::ST_IDLE: begin
				if (in_valid) begin
					op_q         <= in_req.cmd;
					fa_q         <= in_req.free_addr;
					need_q       <= need_d;
					bp_q         <= bta_pkg::LIST_START;
					res_addr_q   <= '0;
					res_status_q <= bta_pkg::STAT_OK;
					if (in_req.cmd == bta_pkg::CMD_INIT)
						bytes_q <= chunk_eff;
					else
						bytes_q <= (need_d > chunk_eff) ? need_d : chunk_eff;
					if (in_req.cmd == bta_pkg::CMD_ALLOC) begin
						if (in_req.req_bytes == '0)
							res_status_q <= bta_pkg::STAT_ZERO;
						else if (brk_q == '0)
							res_status_q <= bta_pkg::STAT_OOM;
					end
				end
			end
			bta_pkg::ST_FIT_CHK: begin
				if ((rd_size >= need_q) && !rd_tag[0])
					s_q <= rd_size;
				else
					bp_q <= bp_q + rd_size;
			end
			bta_pkg::ST_GROW_CALC: gsz_q <= (bytes_q + bta_pkg::WORD) & bta_pkg::SIZE_MASK;
			bta_pkg::ST_GROW_CHK: begin
				if ((brk_ext + gsz_q) > bta_pkg::HEAP_BYTES) begin
					res_status_q <= bta_pkg::STAT_OOM;
				end else begin
					bp_q <= brk_ext;
					s_q  <= gsz_q;
				end
			end
			bta_pkg::ST_MRG_N: p_q <= rd_tag;
			bta_pkg::ST_MRG_D: begin
				if (p_q[0] && !rd_tag[0]) begin
					// absorb the following block
					s_q   <= s_q + rd_size;
					wa1_q <= bp_q - bta_pkg::WORD;
					wa2_q <= bp_q + s_q + rd_size - bta_pkg::DWORD;
				end else if (!p_q[0] && rd_tag[0]) begin
					// fold into the preceding block
					s_q   <= s_q + psz;
					wa1_q <= bp_q - psz - bta_pkg::WORD;
					wa2_q <= bp_q + s_q - bta_pkg::DWORD;
					bp_q  <= bp_q - psz;
				end else if (!p_q[0] && !rd_tag[0]) begin
					s_q   <= s_q + psz + rd_size;
					wa1_q <= bp_q - psz - bta_pkg::WORD;
					wa2_q <= bp_q + s_q + rd_size - bta_pkg::DWORD;
					bp_q  <= bp_q - psz;
				end
			end
			bta_pkg::ST_FREE_DAT: begin
				s_q  <= rd_size;
				bp_q <= fa_ext;
			end
			bta_pkg::ST_PLACE_CALC: begin
				split_q    <= s_q >= (need_q + bta_pkg::MIN_BLOCK);
				wsz_q      <= (s_q >= (need_q + bta_pkg::MIN_BLOCK)) ? need_q : s_q;
				rem_q      <= s_q - need_q;
				res_addr_q <= bp_q[bta_pkg::ADDR_W-1:0];
			end
			default: ;
		endcase
	end

	assign res = {res_status_q, res_addr_q};

`ifndef NO_ASSERTIONS
	a_brk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		brk_ext <= bta_pkg::HEAP_BYTES)
		else $error("heap break past end of tag memory");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bta_pkg::ST_IDLE || state_q == bta_pkg::ST_DONE) |-> !wr_en)
		else $error("tag write outside a command");

	a_zero_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_req.cmd == bta_pkg::CMD_ALLOC && in_req.req_bytes == '0)
		|=> (state_q == bta_pkg::ST_DONE && res_status_q == bta_pkg::STAT_ZERO))
		else $error("zero-size request not answered at once");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_status_q) && $stable(res_addr_q)))
		else $error("result dropped or changed while waiting");
`endif

endmodule
`default_nettype wire

// ----- rtl/boundary_tag_first_fit_allocator_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator_top
// throughput: one command at a time, the single tag memory port sets the pace
// reset: control and the break clear at once; tag memory is not cleared
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// cmd [1:0], req_bytes [20:2], free_addr [38:21], zero pad [39]
	input  logic [bta_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// addr [17:0], status [19:18], zero pad [23:20]
	output logic [bta_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bta_pkg::CHUNK_W-1:0]     cfg_data
);

	logic [bta_pkg::CHUNK_W-1:0] chunk_q;
	bta_pkg::req_t               in_req;
	bta_pkg::res_t               res;
	logic                        res_valid, res_ready;
	logic                        m_tvalid_q;
	logic [bta_pkg::M_TDATA_W-1:0] m_tdata_q;

	// chunk size register, writes always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= bta_pkg::CHUNK_RESET;
		end else if (cfg_valid) begin
			chunk_q <= cfg_data;
		end
	end

	// unpack the input beat: free_addr, req_bytes, cmd from the top down
	assign in_req = s_tdata[38:0];

	bta_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.chunk     (chunk_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (in_req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register: the engine goes back to idle while a beat waits here
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= bta_pkg::M_TDATA_W'({res.status, res.addr});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

// ----- tb/boundary_tag_first_fit_allocator_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator_top_tb
// drives init, allocate, free and idle commands into the allocator through
// several chunk sizes, predicts every result with a tag-level heap model kept
// in step at each accepted beat, and checks the results in order
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator_top_tb;

	localparam int          CLK_HI      = 6;
	localparam int          CLK_LO      = 6;
	localparam int          RST_CYCLES  = 7;
	localparam longint      CYCLE_LIMIT = 6000000;
	localparam int          DRAIN_WAIT  = 40;
	localparam int          LIVE_CAP    = 90;
	localparam logic [18:0] TAG_SZ_MSK  = 19'h7fff8;
	localparam logic [18:0] TAG_ALLOC   = 19'h1;
	localparam longint unsigned HEAP_LIM = longint'(bta_pkg::HEAP_WORDS) * 4;

	typedef struct {
		bta_pkg::cmd_t cmd;
		logic [18:0]   req;
		logic [17:0]   faddr;
	} heap_cmd_t;

	typedef struct {
		logic [17:0]    addr;
		bta_pkg::stat_t status;
	} heap_res_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [bta_pkg::S_TDATA_W-1:0] s_tdata;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [bta_pkg::M_TDATA_W-1:0] m_tdata;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [bta_pkg::CHUNK_W-1:0]   cfg_data;

	// heap image kept by the predictor
	logic [18:0]          tag_mem [bta_pkg::HEAP_WORDS];
	longint unsigned      brk;
	longint unsigned      heap_base;
	longint unsigned      chunk_set;

	heap_cmd_t            cmd_q [$];
	heap_res_t            result_q [$];
	longint unsigned      live_blocks [$];
	heap_cmd_t            on_bus;
	int                   n_pushed;
	int                   n_taken;
	int                   n_errors;
	int                   send_gap;
	int                   recv_gap;
	bit                   calm;
	longint               cyc = 0;

	boundary_tag_first_fit_allocator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#(CLK_HI);
		clk = 1'b0;
		#(CLK_LO);
	end

	// ------------------------------------------------------------------
	// heap predictor
	// ------------------------------------------------------------------
	function automatic logic [18:0] tag_rd(longint unsigned b);
		longint unsigned w;
		w = b >> 2;
		if (w >= bta_pkg::HEAP_WORDS) return '0;
		return tag_mem[w];
	endfunction

	function automatic void tag_wr(longint unsigned b, longint unsigned v);
		longint unsigned w;
		w = b >> 2;
		if (w < bta_pkg::HEAP_WORDS) tag_mem[w] = v[18:0];
	endfunction

	function automatic longint unsigned blk_size(longint unsigned bp);
		return longint'(tag_rd(bp - 4) & TAG_SZ_MSK);
	endfunction

	function automatic longint unsigned foot_of(longint unsigned bp);
		return bp + blk_size(bp) - 8;
	endfunction

	function automatic longint unsigned prev_blk(longint unsigned bp);
		return bp - longint'(tag_rd(bp - 8) & TAG_SZ_MSK);
	endfunction

	function automatic longint unsigned coalesce(longint unsigned bp);
		bit              p_used;
		bit              n_used;
		longint unsigned sz;
		p_used = (tag_rd(foot_of(prev_blk(bp))) & TAG_ALLOC) != 0;
		n_used = (tag_rd(bp + blk_size(bp) - 4) & TAG_ALLOC) != 0;
		sz     = blk_size(bp);
		if (p_used && n_used) return bp;
		if (p_used) begin
			sz += blk_size(bp + blk_size(bp));
			tag_wr(bp - 4, sz);
			tag_wr(foot_of(bp), sz);
		end else if (n_used) begin
			sz += longint'(tag_rd(foot_of(prev_blk(bp))) & TAG_SZ_MSK);
			tag_wr(prev_blk(bp) - 4, sz);
			tag_wr(foot_of(bp), sz);
			bp = prev_blk(bp);
		end else begin
			sz += blk_size(bp + blk_size(bp))
				+ longint'(tag_rd(foot_of(prev_blk(bp))) & TAG_SZ_MSK);
			tag_wr(prev_blk(bp) - 4, sz);
			tag_wr(foot_of(bp + blk_size(bp)), sz);
			bp = prev_blk(bp);
		end
		return bp;
	endfunction

	function automatic bit heap_grow(longint unsigned bytes, output longint unsigned bp);
		longint unsigned words;
		longint unsigned sz;
		words = bytes / 4;
		sz    = (words[0] ? words + 1 : words) * 4;
		bp    = brk;
		if (brk + sz > HEAP_LIM) return 1'b0;
		brk += sz;
		tag_wr(bp - 4, sz);
		tag_wr(foot_of(bp), sz);
		tag_wr(bp + blk_size(bp) - 4, TAG_ALLOC);
		bp = coalesce(bp);
		return 1'b1;
	endfunction

	function automatic longint unsigned chunk_used();
		return (chunk_set < 16) ? 16 : chunk_set;
	endfunction

	function automatic void carve(longint unsigned bp, longint unsigned need);
		longint unsigned csz;
		csz = blk_size(bp);
		if (csz >= need + 16) begin
			tag_wr(bp - 4, need | 1);
			tag_wr(foot_of(bp), need | 1);
			bp = bp + blk_size(bp);
			tag_wr(bp - 4, csz - need);
			tag_wr(foot_of(bp), csz - need);
		end else begin
			tag_wr(bp - 4, csz | 1);
			tag_wr(foot_of(bp), csz | 1);
		end
	endfunction

	function automatic bit first_fit(longint unsigned need, output longint unsigned bp);
		longint unsigned sz;
		bp = heap_base;
		while (bp <= HEAP_LIM) begin
			sz = blk_size(bp);
			if (sz == 0) return 1'b0;
			if (sz >= need && (tag_rd(bp - 4) & TAG_ALLOC) == 0) return 1'b1;
			bp += sz;
		end
		return 1'b0;
	endfunction

	// one command in, one result out
	function automatic heap_res_t heap_step(heap_cmd_t c);
		heap_res_t       r;
		longint unsigned bp;
		longint unsigned need;
		longint unsigned sz;
		r.addr   = '0;
		r.status = bta_pkg::STAT_OK;
		case (c.cmd)
			bta_pkg::CMD_INIT: begin
				live_blocks.delete();
				tag_wr(0, 0);
				tag_wr(4, 9);
				tag_wr(8, 9);
				tag_wr(12, 1);
				brk       = 16;
				heap_base = 8;
				if (!heap_grow(chunk_used(), bp)) r.status = bta_pkg::STAT_OOM;
			end
			bta_pkg::CMD_ALLOC: begin
				if (c.req == 0) begin
					r.status = bta_pkg::STAT_ZERO;
				end else if (brk == 0) begin
					r.status = bta_pkg::STAT_OOM;
				end else begin
					need = (c.req <= 8) ? 16 : 8 * ((longint'(c.req) + 15) / 8);
					if (first_fit(need, bp)) begin
						carve(bp, need);
						r.addr = bp[17:0];
					end else if (heap_grow((need > chunk_used()) ? need : chunk_used(), bp)) begin
						carve(bp, need);
						r.addr = bp[17:0];
					end else begin
						r.status = bta_pkg::STAT_OOM;
					end
					if (r.status == bta_pkg::STAT_OK) live_blocks.push_back(bp);
				end
			end
			bta_pkg::CMD_FREE: begin
				if (brk != 0) begin
					sz = blk_size(c.faddr);
					tag_wr(longint'(c.faddr) - 4, sz);
					tag_wr(foot_of(c.faddr), sz);
					void'(coalesce(c.faddr));
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	task automatic report(string what, longint got, longint want);
		$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
		n_errors++;
	endtask

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55) return 0;
		if (roll < 93) return $urandom_range(1, 4);
		return $urandom_range(15, 70);
	endfunction

	// ------------------------------------------------------------------
	// command beat driver
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				result_q.push_back(heap_step(on_bus));
				n_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					on_bus = cmd_q.pop_front();
					s_tdata  <= {1'b0, on_bus.faddr, on_bus.req, on_bus.cmd};
					s_tvalid <= 1'b1;
					send_gap <= pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result beat monitor, with random back-pressure
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		heap_res_t     want;
		bta_pkg::res_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[19:0];
				if (result_q.size() == 0) begin
					report("result with nothing outstanding", got, 0);
				end else begin
					want = result_q.pop_front();
					if (got.addr !== want.addr) report("addr", got.addr, want.addr);
					if (got.status !== want.status) report("status", got.status, want.status);
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("boundary_tag_first_fit_allocator_top: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	// queue one command and wait until it has been taken, so that the
	// live-block list is current before the next one is chosen
	task automatic send(bta_pkg::cmd_t c, longint unsigned req, longint unsigned fa);
		heap_cmd_t h;
		h.cmd   = c;
		h.req   = req[18:0];
		h.faddr = fa[17:0];
		cmd_q.push_back(h);
		n_pushed++;
		while (n_taken != n_pushed) @(posedge clk);
	endtask

	task automatic free_live(int idx);
		longint unsigned a;
		a = live_blocks[idx];
		live_blocks.delete(idx);
		send(bta_pkg::CMD_FREE, $urandom_range(0, 524287), a);
	endtask

	task automatic drain();
		while (n_taken != n_pushed || result_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_chunk(longint unsigned v);
		drain();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v[bta_pkg::CHUNK_W-1:0];
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		chunk_set = v;
	endtask

	function automatic longint unsigned rand_req();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 2) return 0;
		if (roll < 60) return $urandom_range(1, 64);
		if (roll < 92) return $urandom_range(65, 1500);
		if (roll < 98) return $urandom_range(1501, 40000);
		return $urandom_range(40001, 262144);
	endfunction

	task automatic random_run(int n);
		int roll;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (live_blocks.size() >= LIVE_CAP && roll < 80)
				roll = 90;
			if (roll < 2)
				send(bta_pkg::CMD_INIT, $urandom_range(0, 524287), $urandom_range(0, 262143));
			else if (roll < 4)
				send(bta_pkg::CMD_NONE, $urandom_range(0, 524287), $urandom_range(0, 262143));
			else if (roll < 58 || live_blocks.size() == 0)
				send(bta_pkg::CMD_ALLOC, rand_req(), $urandom_range(0, 262143));
			else
				free_live($urandom_range(0, live_blocks.size() - 1));
		end
	endtask

	initial begin
		cfg_valid = 1'b0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		n_pushed  = 0;
		n_taken   = 0;
		n_errors  = 0;
		calm      = 1'b0;
		brk       = 0;
		heap_base = 0;
		chunk_set = 4096;
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// before init: allocate runs out of memory, free and the idle code do nothing
		send(bta_pkg::CMD_ALLOC, 24, 0);
		send(bta_pkg::CMD_FREE, 0, 262143);
		send(bta_pkg::CMD_NONE, 524287, 262143);
		// fresh heap, zero-size and minimum requests, rounding edges
		send(bta_pkg::CMD_INIT, 0, 0);
		send(bta_pkg::CMD_ALLOC, 0, 0);
		send(bta_pkg::CMD_ALLOC, 1, 0);
		send(bta_pkg::CMD_ALLOC, 8, 0);
		send(bta_pkg::CMD_ALLOC, 9, 0);
		send(bta_pkg::CMD_ALLOC, 24, 0);
		send(bta_pkg::CMD_ALLOC, 100, 0);
		// free with both neighbours in use, then the block before it, the last block and the first
		free_live(2);
		free_live(1);
		free_live(2);
		free_live(0);
		// whole-heap request cannot fit; growth past the current break
		send(bta_pkg::CMD_ALLOC, 262144, 0);
		send(bta_pkg::CMD_ALLOC, 150000, 0);
		send(bta_pkg::CMD_ALLOC, 50000, 0);
		free_live(live_blocks.size() - 1);
		free_live(0);
		send(bta_pkg::CMD_ALLOC, 5000, 0);
		// pause the sender until everything is back
		drain();
		random_run(550);

		// smallest chunk, in stretches with no idling
		set_chunk(16);
		calm = 1'b1;
		send(bta_pkg::CMD_INIT, 0, 0);
		random_run(300);
		calm = 1'b0;
		random_run(100);

		// below the minimum, treated as the minimum
		set_chunk(0);
		send(bta_pkg::CMD_INIT, 0, 0);
		random_run(250);

		// chunk as large as the heap: init itself runs out of memory
		set_chunk(262144);
		send(bta_pkg::CMD_INIT, 0, 0);
		send(bta_pkg::CMD_ALLOC, 16, 0);
		random_run(30);

		set_chunk(131072);
		send(bta_pkg::CMD_INIT, 0, 0);
		random_run(300);

		set_chunk($urandom_range(16, 20000));
		send(bta_pkg::CMD_INIT, 0, 0);
		random_run(380);

		drain();
		if (n_errors == 0)
			$display("boundary_tag_first_fit_allocator_top: match");
		else
			$display("boundary_tag_first_fit_allocator_top: mismatch");
		$finish;
	end

endmodule
